// ===== rtl/core/first_fit_bin_packer_unit_macros.svh =====
// Assertion macros shared by the RTL of the first-fit bin packer.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef FIRST_FIT_BIN_PACKER_UNIT_MACROS_SVH
`define FIRST_FIT_BIN_PACKER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFBP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ffbp_pkg.sv =====
`timescale 1ns / 1ps

package ffbp_pkg;

  localparam int FILL_W    = 16;
  localparam int IDX_OUT_W = 6;
  localparam int CNT_W     = 7;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [CNT_W-1:0]  CNT_MAX   = 7'd127;
  localparam logic [FILL_W-1:0] CAP_RESET = 16'hFFFF;

  // Register index as seen in paddr[2].
  localparam logic REG_BIN_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/ffbp_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered read data.
module ffbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/first_fit_bin_packer_unit.sv =====
`timescale 1ns / 1ps

// First-fit bin packer. Each accepted item is placed in the lowest-numbered bin whose fill
// plus the item size does not exceed the bin_capacity register, and one result item reports
// the chosen bin, whether the item was placed, and the number of non-empty bins. The fills
// live in a single RAM of MAX_BINS words that is scanned one bin per cycle through its
// registered read port. Bins at or above a high-water mark have never been written since
// reset or the last first_item and read as empty, so no clearing pass is needed and the scan
// stops at the first such bin. An item makes the block look at k bins (k is at most the
// number of bins touched so far plus one, and never more than MAX_BINS): the first bin is
// read, the bins are compared in order, and the result is loaded into the output register
// once that register is free or its result is being taken; the next item can be accepted
// once the result is offered. The block works on one item at a time; a new item may be
// accepted while the previous result still waits to be taken. The capacity is written
// through the APB port at byte address 0 and should only be changed while no item is in
// flight.
module first_fit_bin_packer_unit #(
  parameter int MAX_BINS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [15:0]                 in_item_size,
  input  logic                        in_first_item,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [5:0]                  out_bin_index,
  output logic                        out_placed,
  output logic [6:0]                  out_bins_used,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffbp_pkg::ADDR_W-1:0] paddr,
  input  logic [ffbp_pkg::DATA_W-1:0] pwdata,
  output logic [ffbp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  `include "first_fit_bin_packer_unit_macros.svh"

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int HW_W  = $clog2(MAX_BINS + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BINS - 1);
  localparam logic [HW_W-1:0]  HW_MAX   = HW_W'(MAX_BINS);

  // Control and scan state.
  ffbp_pkg::state_t state_r, state_nxt;
  logic [ffbp_pkg::FILL_W-1:0]    cap_r;
  logic [ffbp_pkg::FILL_W-1:0]    size_r, size_nxt;
  logic [HW_W-1:0]                hw_r, hw_nxt;
  logic [ffbp_pkg::CNT_W-1:0]     used_r, used_nxt;
  logic [IDX_W-1:0]               rd_idx_r, rd_idx_nxt;
  logic                           cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]               cmp_idx_r, cmp_idx_nxt;
  logic [ffbp_pkg::IDX_OUT_W-1:0] res_idx_r, res_idx_nxt;
  logic                           res_placed_r, res_placed_nxt;

  // Output register.
  logic                           out_valid_r, out_valid_nxt;
  logic [ffbp_pkg::IDX_OUT_W-1:0] out_bin_index_r, out_bin_index_nxt;
  logic                           out_placed_r, out_placed_nxt;
  logic [ffbp_pkg::CNT_W-1:0]     out_bins_used_r, out_bins_used_nxt;

  // RAM ports.
  logic                        ram_we, ram_re;
  logic [IDX_W-1:0]            ram_waddr;
  logic [ffbp_pkg::FILL_W-1:0] ram_wdata, ram_rdata;

  // Datapath for the bin under test.
  logic                          cmp_in_hw;
  logic [ffbp_pkg::FILL_W-1:0]   fill_w;
  logic [ffbp_pkg::FILL_W:0]     sum_w;
  logic                          fits_w;
  logic                          last_w;
  logic                          hit_w;
  logic                          cfg_wr;

  ffbp_ram #(
    .WIDTH (ffbp_pkg::FILL_W),
    .DEPTH (MAX_BINS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // Configuration port: a single register, always ready.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ffbp_pkg::REG_BIN_CAPACITY);
  assign prdata = (paddr[2] == ffbp_pkg::REG_BIN_CAPACITY) ?
                  {{(ffbp_pkg::DATA_W - ffbp_pkg::FILL_W){1'b0}}, cap_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= ffbp_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[ffbp_pkg::FILL_W-1:0];
    end
  end

  // Bins at or above the high-water mark have never been written since reset or the last first item and read as zero.
  assign cmp_in_hw = HW_W'(cmp_idx_r) < hw_r;
  assign fill_w    = cmp_in_hw ? ram_rdata : '0;
  assign sum_w     = {1'b0, fill_w} + {1'b0, size_r};
  assign fits_w    = sum_w <= {1'b0, cap_r};
  assign last_w    = cmp_idx_r == LAST_IDX;
  assign hit_w     = (state_r == ffbp_pkg::S_SCAN) && cmp_vld_r && fits_w;

  assign in_ready = (state_r == ffbp_pkg::S_IDLE);

  always_comb begin
    state_nxt         = state_r;
    size_nxt          = size_r;
    hw_nxt            = hw_r;
    used_nxt          = used_r;
    rd_idx_nxt        = rd_idx_r;
    cmp_vld_nxt       = cmp_vld_r;
    cmp_idx_nxt       = cmp_idx_r;
    res_idx_nxt       = res_idx_r;
    res_placed_nxt    = res_placed_r;
    out_valid_nxt     = out_valid_r;
    out_bin_index_nxt = out_bin_index_r;
    out_placed_nxt    = out_placed_r;
    out_bins_used_nxt = out_bins_used_r;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    ram_waddr         = cmp_idx_r;
    ram_wdata         = sum_w[ffbp_pkg::FILL_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ffbp_pkg::S_IDLE: begin
        if (in_valid) begin
          size_nxt    = in_item_size;
          rd_idx_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          if (in_first_item) begin
            hw_nxt   = '0;
            used_nxt = '0;
          end
          state_nxt = ffbp_pkg::S_SCAN;
        end
      end

      ffbp_pkg::S_SCAN: begin
        // One read is issued per cycle; its data is tested in the following cycle.
        ram_re      = 1'b1;
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = rd_idx_r;
        if (rd_idx_r != LAST_IDX) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (cmp_vld_r) begin
          if (fits_w) begin
            ram_we = 1'b1;
            if ((fill_w == '0) && (size_r != '0) && (used_r < ffbp_pkg::CNT_MAX)) begin
              used_nxt = used_r + 1'b1;
            end
            if (!cmp_in_hw) begin
              hw_nxt = hw_r + 1'b1;
            end
            res_idx_nxt    = ffbp_pkg::IDX_OUT_W'(cmp_idx_r);
            res_placed_nxt = 1'b1;
            state_nxt      = ffbp_pkg::S_DONE;
          end else if (!cmp_in_hw || last_w) begin
            // An empty bin that cannot take the item means no later bin can either; the scan also ends at the last bin.
            res_idx_nxt    = '0;
            res_placed_nxt = 1'b0;
            state_nxt      = ffbp_pkg::S_DONE;
          end
        end
      end

      ffbp_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_bin_index_nxt = res_idx_r;
          out_placed_nxt    = res_placed_r;
          out_bins_used_nxt = used_r;
          state_nxt         = ffbp_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ffbp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffbp_pkg::S_IDLE;
      hw_r        <= '0;
      used_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      used_r      <= used_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r          <= size_nxt;
    rd_idx_r        <= rd_idx_nxt;
    cmp_idx_r       <= cmp_idx_nxt;
    res_idx_r       <= res_idx_nxt;
    res_placed_r    <= res_placed_nxt;
    out_bin_index_r <= out_bin_index_nxt;
    out_placed_r    <= out_placed_nxt;
    out_bins_used_r <= out_bins_used_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_bin_index = out_bin_index_r;
  assign out_placed    = out_placed_r;
  assign out_bins_used = out_bins_used_r;

  `FFBP_ASSERT_SAME(a_hw_bound, 1'b1, hw_r <= HW_MAX, "high-water mark beyond the bin count")
  `FFBP_ASSERT_NEXT(a_hw_grow, hit_w && !cmp_in_hw, hw_r == $past(hw_r) + 1'b1,
                    "high-water mark did not grow")
  `FFBP_ASSERT_NEXT(a_accept_scan, in_valid && in_ready, state_r == ffbp_pkg::S_SCAN,
                    "accepted item did not start a scan")
  `FFBP_ASSERT_SAME(a_reject_idx, out_valid && !out_placed, out_bin_index == '0,
                    "rejected item reports a nonzero bin")

endmodule
